/* rtl/core/ptt_pkg.sv */
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and constants for the periodic timer table
// Slot count, result codes, opcodes, the stored slot record and the
// controller state type.
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam int SLOTS    = 16;
	localparam int IDX_W    = $clog2(SLOTS);
	localparam int CNT_W    = $clog2(SLOTS + 1);
	localparam int MAX_FIRE = 16;
	localparam int FC_W     = $clog2(MAX_FIRE + 1);

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_DEL  = 2'd1,
		OP_TICK = 2'd2
	} op_t;

	localparam logic [2:0] KIND_ADDED   = 3'd0;
	localparam logic [2:0] KIND_FULL    = 3'd1;
	localparam logic [2:0] KIND_DELETED = 3'd2;
	localparam logic [2:0] KIND_MISS    = 3'd3;
	localparam logic [2:0] KIND_FIRED   = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [7:0]  job;
		logic [31:0] due;
		logic [15:0] delay;
		logic [15:0] remaining;
		logic        periodic;
	} entry_t;

	typedef struct packed {
		logic       fire;
		logic       retire;
		entry_t     wb;
	} eval_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
	} alloc_t;

endpackage

/* rtl/core/periodic_timer_table.sv */
// ----------------------------------------------------------------------------
// periodic_timer_table: table of repeating timer slots
// Add, delete and tick commands on a slot table held in a memory.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one command per
//   transaction: add, delete or tick. Each is taken only while the
//   controller is idle; the block works on one command at a time.
//   Add and delete give exactly one result transaction, loaded into the
//   output register from the EXEC state once that register is free; the
//   controller then returns to idle for the next command. A tick scans all
//   SLOTS slots, one per cycle through the memory read port unless a stall
//   holds the scan, then flushes its final result and returns to idle.
//   It gives one result per fired slot in slot order, the last one flagged.
//   A tick that fires nothing gives no result. Unknown opcodes are dropped.
//   Results sit in an output register; while the receiver stalls, the
//   scan halts on the next firing, since one fired result is held back
//   in a pending register until it is known whether it is the last.
//   A new command can be accepted while the final result still waits.
//   Reset clears all slot valid bits at once; record memory needs no pass.
// ----------------------------------------------------------------------------
module periodic_timer_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  job_id,
	input  logic [31:0] start_time,
	input  logic [15:0] repeat_delay,
	input  logic [15:0] repeat_count,
	input  logic        periodic,
	input  logic [3:0]  target_slot,
	input  logic [31:0] now_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [3:0]  slot,
	output logic [7:0]  fired_job,
	output logic        retired,
	output logic        last
);
	import ptt_pkg::*;

	// controller state
	state_t state_q, state_d;

	// latched command
	logic [1:0]  op_q;
	logic [7:0]  job_q;
	logic [31:0] start_q;
	logic [15:0] delay_q;
	logic [15:0] count_q;
	logic        per_q;
	logic [3:0]  tgt_q;
	logic [31:0] now_q;

	// slot valid bits live in flops so reset clears them at once
	logic [SLOTS-1:0] valid_q;

	// scan pipeline: read issue counter, then one stage holding the slot read
	logic [CNT_W-1:0] rd_cnt_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [FC_W-1:0]  fire_cnt_q;

	// fired result held back until we know whether it is the last
	logic        pend_vld_q;
	logic [3:0]  pend_slot_q;
	logic [7:0]  pend_job_q;
	logic        pend_ret_q;

	// output register
	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [3:0]  slot_q;
	logic [7:0]  job_out_q;
	logic        ret_q;
	logic        last_q;

	// memory ports
	logic             mem_we, mem_re;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	entry_t           mem_wdata, mem_rdata;

	alloc_t alloc;
	eval_t  ev;

	// combinational controls
	logic             out_free;
	logic             out_load;
	logic [2:0]       o_kind;
	logic [3:0]       o_slot;
	logic [7:0]       o_job;
	logic             o_ret;
	logic             o_last;
	logic             vwr;
	logic             vwr_val;
	logic [IDX_W-1:0] vwr_idx;
	logic             pend_set, pend_clr;
	logic             scan_init;
	logic             issue;
	logic             s1_adv;
	logic             fire_take;
	logic             stall;
	logic             del_hit;
	logic [IDX_W-1:0] tgt_idx;
	logic             scan_done;

	ptt_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ptt_alloc u_alloc (
		.slot_valid (valid_q),
		.alloc      (alloc)
	);

	ptt_fire_eval u_eval (
		.ent      (mem_rdata),
		.slot_vld (rd_vld_s1 && valid_q[rd_idx_s1]),
		.limit_ok (fire_cnt_q < FC_W'(MAX_FIRE)),
		.now      (now_q),
		.res      (ev)
	);

	assign out_free  = !out_valid_q || out_ready;
	assign tgt_idx   = IDX_W'(tgt_q);
	// an index beyond the table is a miss
	assign del_hit   = (32'(tgt_q) < 32'(SLOTS)) && valid_q[tgt_idx];
	// a second firing needs the held one moved to the output register first
	assign stall     = rd_vld_s1 && ev.fire && pend_vld_q && !out_free;
	assign scan_done = !rd_vld_s1 && (rd_cnt_q == CNT_W'(SLOTS));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (op_q)
					OP_ADD, OP_DEL: begin
						if (out_free) state_d = ST_IDLE;
					end
					OP_TICK: state_d = ST_SCAN;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!pend_vld_q || out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// controls
	always_comb begin
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = ev.wb;
		mem_re    = 1'b0;
		mem_raddr = rd_cnt_q[IDX_W-1:0];
		out_load  = 1'b0;
		o_kind    = KIND_FIRED;
		o_slot    = pend_slot_q;
		o_job     = pend_job_q;
		o_ret     = pend_ret_q;
		o_last    = 1'b0;
		vwr       = 1'b0;
		vwr_val   = 1'b0;
		vwr_idx   = rd_idx_s1;
		pend_set  = 1'b0;
		pend_clr  = 1'b0;
		scan_init = 1'b0;
		issue     = 1'b0;
		s1_adv    = 1'b0;
		fire_take = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_EXEC: begin
				case (op_q)
					OP_ADD: begin
						if (out_free) begin
							out_load = 1'b1;
							o_job    = 8'd0;
							o_ret    = 1'b0;
							o_last   = 1'b1;
							if (alloc.found) begin
								mem_we              = 1'b1;
								mem_waddr           = alloc.idx;
								mem_wdata.job       = job_q;
								mem_wdata.due       = start_q;
								mem_wdata.delay     = (delay_q == 16'd0) ? 16'd1 : delay_q;
								mem_wdata.remaining = count_q;
								mem_wdata.periodic  = per_q;
								vwr                 = 1'b1;
								vwr_val             = 1'b1;
								vwr_idx             = alloc.idx;
								o_kind              = KIND_ADDED;
								o_slot              = 4'(alloc.idx);
							end else begin
								o_kind = KIND_FULL;
								o_slot = 4'd0;
							end
						end
					end
					OP_DEL: begin
						if (out_free) begin
							out_load = 1'b1;
							o_job    = 8'd0;
							o_ret    = 1'b0;
							o_last   = 1'b1;
							o_slot   = tgt_q;
							o_kind   = del_hit ? KIND_DELETED : KIND_MISS;
							vwr      = del_hit;
							vwr_idx  = tgt_idx;
						end
					end
					OP_TICK: scan_init = 1'b1;
					default: ;
				endcase
			end
			ST_SCAN: begin
				if (!stall) begin
					s1_adv = 1'b1;
					if (rd_vld_s1 && ev.fire) begin
						fire_take = 1'b1;
						pend_set  = 1'b1;
						out_load  = pend_vld_q;
						if (ev.retire) begin
							vwr     = 1'b1;
							vwr_idx = rd_idx_s1;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = rd_idx_s1;
						end
					end
					if (rd_cnt_q < CNT_W'(SLOTS)) begin
						issue  = 1'b1;
						mem_re = 1'b1;
					end
				end
			end
			ST_FLUSH: begin
				if (pend_vld_q && out_free) begin
					out_load = 1'b1;
					o_last   = 1'b1;
					pend_clr = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			pend_vld_q  <= 1'b0;
			rd_vld_s1   <= 1'b0;
			rd_cnt_q    <= '0;
			fire_cnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (vwr) valid_q[vwr_idx] <= vwr_val;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pend_set) begin
				pend_vld_q <= 1'b1;
			end else if (pend_clr) begin
				pend_vld_q <= 1'b0;
			end
			if (scan_init) begin
				rd_vld_s1  <= 1'b0;
				rd_cnt_q   <= '0;
				fire_cnt_q <= '0;
			end else if (s1_adv) begin
				rd_vld_s1 <= issue;
				if (issue) rd_cnt_q <= rd_cnt_q + CNT_W'(1);
				if (fire_take) fire_cnt_q <= fire_cnt_q + FC_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q    <= opcode;
			job_q   <= job_id;
			start_q <= start_time;
			delay_q <= repeat_delay;
			count_q <= repeat_count;
			per_q   <= periodic;
			tgt_q   <= target_slot;
			now_q   <= now_time;
		end
		if (s1_adv && issue) rd_idx_s1 <= rd_cnt_q[IDX_W-1:0];
		if (pend_set) begin
			pend_slot_q <= 4'(rd_idx_s1);
			pend_job_q  <= mem_rdata.job;
			pend_ret_q  <= ev.retire;
		end
		if (out_load) begin
			kind_q    <= o_kind;
			slot_q    <= o_slot;
			job_out_q <= o_job;
			ret_q     <= o_ret;
			last_q    <= o_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign slot      = slot_q;
	assign fired_job = job_out_q;
	assign retired   = ret_q;
	assign last      = last_q;

`ifndef ASSERT_OFF
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mem_we)
		else $error("memory written while idle");

	a_fire_limit: assert property (@(posedge clk) disable iff (!arst_n)
		fire_cnt_q <= FC_W'(MAX_FIRE))
		else $error("firing count beyond limit");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_EXEC))
		else $error("accepted command not executed");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind != KIND_FIRED)) |-> last)
		else $error("add or delete result without last");

	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && !pend_vld_q) |=> (state_q == ST_IDLE))
		else $error("flush did not return to idle");
`endif

endmodule

/* rtl/core/ptt_mem.sv */
// ----------------------------------------------------------------------------
// ptt_mem: slot record memory
// One write port, one read port with a registered, enable-held read.
// ----------------------------------------------------------------------------
module ptt_mem (
	input  logic                      clk,
	input  logic                      we,
	input  logic [ptt_pkg::IDX_W-1:0] waddr,
	input  ptt_pkg::entry_t           wdata,
	input  logic                      re,
	input  logic [ptt_pkg::IDX_W-1:0] raddr,
	output ptt_pkg::entry_t           rdata
);
	import ptt_pkg::*;

	entry_t mem_q [SLOTS];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/ptt_alloc.sv */
// ----------------------------------------------------------------------------
// ptt_alloc: free slot finder
// Priority encoder returning the lowest slot whose valid bit is clear.
// ----------------------------------------------------------------------------
module ptt_alloc (
	input  logic [ptt_pkg::SLOTS-1:0] slot_valid,
	output ptt_pkg::alloc_t           alloc
);
	import ptt_pkg::*;

	always_comb begin
		alloc = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!slot_valid[i]) begin
				alloc.found = 1'b1;
				alloc.idx   = IDX_W'(i);
			end
		end
	end

endmodule

/* rtl/core/ptt_fire_eval.sv */
// ----------------------------------------------------------------------------
// ptt_fire_eval: per-slot tick evaluation
// Decides fire and retire for one slot record and builds its re-armed copy.
// ----------------------------------------------------------------------------
module ptt_fire_eval (
	input  ptt_pkg::entry_t ent,
	input  logic            slot_vld,
	input  logic            limit_ok,
	input  logic [31:0]     now,
	output ptt_pkg::eval_t  res
);
	import ptt_pkg::*;

	always_comb begin
		res.fire   = slot_vld && limit_ok && (ent.due <= now);
		// count 0 repeats forever, count above 1 re-arms
		res.retire = !ent.periodic || (ent.remaining == 16'd1);
		res.wb     = ent;
		res.wb.due = now + 32'(ent.delay);
		if (ent.remaining > 16'd1) begin
			res.wb.remaining = ent.remaining - 16'd1;
		end
	end

endmodule

/* dv/tb_periodic_timer_table.sv */
// ----------------------------------------------------------------------------
// tb_periodic_timer_table: self-checking bench for the periodic timer table
// Drives add, delete and tick commands over the valid/ready input channel.
// An in-bench scoreboard model of the slot table predicts every result
// transaction, and each one taken from the output channel is compared
// against the oldest prediction. Directed cases come first, then a long
// hold-off on the output side, then random traffic with idle gaps on
// both channels.
// ----------------------------------------------------------------------------
module tb_periodic_timer_table;
	timeunit 1ns;
	timeprecision 1ps;

	import ptt_pkg::*;

	// opcode 3 has no meaning to the block; it must be dropped silently
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int RANDOM_ITEMS   = 300;
	localparam int LONG_HOLD      = 300;
	// a tick walks all slots and then drains its scan pipeline
	localparam int TAIL_CYCLES    = 2 * SLOTS + 8;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  job;
		logic [31:0] start;
		logic [15:0] delay;
		logic [15:0] count;
		logic        periodic;
		logic [3:0]  target;
		logic [31:0] now;
	} timer_cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] slot;
		logic [7:0] job;
		logic       retired;
		logic       last;
	} timer_event_t;

	// ------------------------------------------------------------------------
	// DUT ports; every input starts at a known value
	// ------------------------------------------------------------------------
	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode       = '0;
	logic [7:0]  job_id       = '0;
	logic [31:0] start_time   = '0;
	logic [15:0] repeat_delay = '0;
	logic [15:0] repeat_count = '0;
	logic        periodic     = 1'b0;
	logic [3:0]  target_slot  = '0;
	logic [31:0] now_time     = '0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [2:0]  kind;
	logic [3:0]  slot;
	logic [7:0]  fired_job;
	logic        retired;
	logic        last;

	periodic_timer_table DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.job_id       (job_id),
		.start_time   (start_time),
		.repeat_delay (repeat_delay),
		.repeat_count (repeat_count),
		.periodic     (periodic),
		.target_slot  (target_slot),
		.now_time     (now_time),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.slot         (slot),
		.fired_job    (fired_job),
		.retired      (retired),
		.last         (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Scoreboard copy of the slot table. Records of a slot are only read
	// while its armed bit is set, same as the hardware.
	// ------------------------------------------------------------------------
	logic        tbl_armed  [SLOTS] = '{default: 1'b0};
	logic [7:0]  tbl_job    [SLOTS];
	logic [31:0] tbl_due    [SLOTS];
	logic [15:0] tbl_step   [SLOTS];
	logic [15:0] tbl_left   [SLOTS];
	logic        tbl_repeat [SLOTS];

	timer_event_t expected_events [$];

	int   failures      = 0;
	bit   no_idle       = 1'b0;   // both channels run back to back when set
	bit   hold_request  = 1'b0;   // asks the receiver for one long hold-off
	bit   hold_active   = 1'b0;
	logic [31:0] wall_now = 32'd20; // running clock for random ticks

	function automatic void note_failure(input string msg);
		failures++;
		if (failures <= 10)
			$display("[%0t] ERROR: %s", $time, msg);
	endfunction

	// Updates the scoreboard table for one accepted command and queues
	// the result transactions it should produce.
	function automatic void predict_timer_events(input timer_cmd_t c);
		timer_event_t ev;
		int           i;
		int           fired;
		logic         drop;
		bit           placed;
		ev     = '0;
		fired  = 0;
		placed = 1'b0;
		case (c.op)
			OP_ADD: begin
				// lowest free slot wins
				for (i = 0; i < SLOTS && !placed; i++) begin
					if (!tbl_armed[i]) begin
						tbl_armed[i]  = 1'b1;
						tbl_job[i]    = c.job;
						tbl_due[i]    = c.start;
						tbl_step[i]   = (c.delay == '0) ? 16'd1 : c.delay;
						tbl_left[i]   = c.count;
						tbl_repeat[i] = c.periodic;
						ev.kind       = KIND_ADDED;
						ev.slot       = 4'(i);
						placed        = 1'b1;
					end
				end
				if (!placed)
					ev.kind = KIND_FULL;
				ev.last = 1'b1;
				expected_events.push_back(ev);
			end
			OP_DEL: begin
				ev.slot = c.target;
				if (int'(c.target) < SLOTS && tbl_armed[c.target]) begin
					tbl_armed[c.target] = 1'b0;
					ev.kind = KIND_DELETED;
				end else begin
					ev.kind = KIND_MISS;
				end
				ev.last = 1'b1;
				expected_events.push_back(ev);
			end
			OP_TICK: begin
				for (i = 0; i < SLOTS && fired < MAX_FIRE; i++) begin
					if (tbl_armed[i] && tbl_due[i] <= c.now) begin
						// one-shot and exhausted timers leave; count 0 repeats forever
						drop = 1'b1;
						if (tbl_repeat[i]) begin
							if (tbl_left[i] == '0) begin
								drop = 1'b0;
							end else if (tbl_left[i] > 16'd1) begin
								tbl_left[i] = tbl_left[i] - 16'd1;
								drop = 1'b0;
							end
						end
						if (drop)
							tbl_armed[i] = 1'b0;
						else
							tbl_due[i] = c.now + 32'(tbl_step[i]); // wraps mod 2^32
						ev.kind    = KIND_FIRED;
						ev.slot    = 4'(i);
						ev.job     = tbl_job[i];
						ev.retired = drop;
						ev.last    = 1'b0;
						expected_events.push_back(ev);
						fired++;
					end
				end
				if (fired > 0) begin
					ev      = expected_events.pop_back();
					ev.last = 1'b1;
					expected_events.push_back(ev);
				end
			end
			default: begin
				// dropped by the block, nothing to expect
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Idle gaps: mostly none or short, now and then a long one
	// ------------------------------------------------------------------------
	function automatic int idle_gap();
		int r;
		r = int'($urandom_range(99));
		if (no_idle || r < 50)
			return 0;
		if (r < 90)
			return int'($urandom_range(3, 1));
		return int'($urandom_range(40, 8));
	endfunction

	// All fields random; the helpers below overwrite what matters, so the
	// unused fields of every command still toggle.
	function automatic timer_cmd_t filler_command();
		timer_cmd_t c;
		c = timer_cmd_t'({$urandom, $urandom, $urandom, $urandom});
		return c;
	endfunction

	// ------------------------------------------------------------------------
	// Sender: one transaction on the input channel. Valid is only lowered
	// when a gap is taken, so back-to-back commands keep it high.
	// ------------------------------------------------------------------------
	task automatic send_command(input timer_cmd_t c);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= c.op;
		job_id       <= c.job;
		start_time   <= c.start;
		repeat_delay <= c.delay;
		repeat_count <= c.count;
		periodic     <= c.periodic;
		target_slot  <= c.target;
		now_time     <= c.now;
		do @(posedge clk); while (!in_ready);
		predict_timer_events(c);
	endtask

	task automatic add_timer(input logic [7:0] job, input logic [31:0] start,
			input logic [15:0] delay, input logic [15:0] count, input logic rep);
		timer_cmd_t c;
		c          = filler_command();
		c.op       = OP_ADD;
		c.job      = job;
		c.start    = start;
		c.delay    = delay;
		c.count    = count;
		c.periodic = rep;
		send_command(c);
	endtask

	task automatic delete_timer(input logic [3:0] target);
		timer_cmd_t c;
		c        = filler_command();
		c.op     = OP_DEL;
		c.target = target;
		send_command(c);
	endtask

	task automatic tick_at(input logic [31:0] now);
		timer_cmd_t c;
		c     = filler_command();
		c.op  = OP_TICK;
		c.now = now;
		send_command(c);
	endtask

	// Random command shaped like real use: due times near the running
	// clock, short delays and counts, deletes mostly of live slots, ticks
	// moving forward. A small share is full-range noise.
	function automatic timer_cmd_t random_command();
		timer_cmd_t c;
		int         r;
		int         live [$];
		c = filler_command();
		r = int'($urandom_range(99));
		if (r < 3) begin
			c.op = OP_UNUSED;
		end else if (r < 41) begin
			c.op = OP_ADD;
			r = int'($urandom_range(99));
			if (r < 80)
				c.start = wall_now + 32'($urandom_range(8));
			else if (r < 90)
				c.start = wall_now - 32'($urandom_range(8));
			r = int'($urandom_range(99));
			if (r < 70)
				c.delay = 16'($urandom_range(6, 1));
			else if (r < 80)
				c.delay = '0;
			else if (r < 88)
				c.delay = '1;
			r = int'($urandom_range(99));
			if (r < 85)
				c.count = 16'($urandom_range(4));
			else if (r < 90)
				c.count = '1;
		end else if (r < 68) begin
			c.op = OP_DEL;
			if ($urandom_range(99) < 75) begin
				for (int i = 0; i < SLOTS; i++)
					if (tbl_armed[i])
						live.push_back(i);
				if (live.size() > 0)
					c.target = 4'(live[$urandom_range(live.size() - 1)]);
			end
		end else begin
			c.op = OP_TICK;
			r = int'($urandom_range(99));
			if (r < 90) begin
				wall_now = wall_now + 32'($urandom_range(4));
				c.now    = wall_now;
			end else if (r < 96) begin
				wall_now = $urandom;
				c.now    = wall_now;
			end
			// else: stray tick at a random time, clock left alone
		end
		return c;
	endfunction

	// ------------------------------------------------------------------------
	// Receiver: random ready with runs and gaps; serves one long hold-off
	// on request so the block backs up into its input.
	// ------------------------------------------------------------------------
	initial begin
		int run_len;
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				out_ready   <= 1'b0;
				hold_active  = 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
				hold_active  = 1'b0;
			end else begin
				out_ready <= 1'b1;
				run_len = int'($urandom_range(20, 1));
				repeat (run_len) @(posedge clk);
				gap = idle_gap();
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result checker: every output transaction against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		timer_event_t got;
		timer_event_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{kind: kind, slot: slot, job: fired_job, retired: retired, last: last};
			if (expected_events.size() == 0) begin
				note_failure($sformatf("unexpected result kind=%0d slot=%0d job=%0h ret=%0b last=%0b",
					got.kind, got.slot, got.job, got.retired, got.last));
			end else begin
				want = expected_events.pop_front();
				if (got !== want)
					note_failure($sformatf(
						"kind %0d/%0d slot %0d/%0d job %0h/%0h ret %0b/%0b last %0b/%0b (exp/act)",
						want.kind, got.kind, want.slot, got.slot, want.job, got.job,
						want.retired, got.retired, want.last, got.last));
			end
		end
	end

	// Watchdog: too long without any transaction on either channel
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("** periodic_timer_table: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Tick on an empty table gives nothing; opcode 3 is dropped.
	task automatic test_empty_tick();
		timer_cmd_t c;
		tick_at(32'd100);
		c    = filler_command();
		c.op = OP_UNUSED;
		send_command(c);
	endtask

	// Fill all slots with a spread of field extremes, then one more add
	// must report a full table.
	task automatic test_fill_table();
		add_timer(8'h00, 32'd0,          16'd0,     16'd0,     1'b1); // delay 0 -> 1
		add_timer(8'hFF, 32'd10,         16'hFFFF,  16'd0,     1'b1);
		add_timer(8'h5A, 32'd10,         16'd3,     16'd1,     1'b1); // single shot
		add_timer(8'hA5, 32'd10,         16'd2,     16'd2,     1'b1);
		add_timer(8'h11, 32'd10,         16'd5,     16'hFFFF,  1'b1);
		add_timer(8'h22, 32'd10,         16'd7,     16'd3,     1'b0); // one-shot
		add_timer(8'h33, 32'hFFFF_FFFF,  16'd4,     16'd0,     1'b1); // re-arm wraps
		add_timer(8'h44, 32'd11,         16'd9,     16'd0,     1'b1);
		for (int i = 8; i < SLOTS; i++)
			add_timer(8'(8'h80 + i), i[0] ? 32'hFFFF_FFFF : 32'(i),
				16'(i * 4099), 16'(i - 7), i[1]);
		add_timer(8'hEE, 32'd0, 16'd1, 16'd1, 1'b0);
	endtask

	// Delete a live slot, then the same slot again for a miss.
	task automatic test_delete();
		delete_timer(4'd7);
		delete_timer(4'd7);
	endtask

	// First tick fires the early slots, the max-time tick fires the rest and
	// wraps the re-arm times, the third catches the wrapped ones.
	task automatic test_tick_firing();
		tick_at(32'd10);
		tick_at(32'hFFFF_FFFF);
		tick_at(32'd5);
	endtask

	// Receiver holds off for a long stretch while commands keep coming;
	// the block has to stall its input.
	task automatic test_backpressure();
		// nothing offered while waiting for the hold-off to start
		in_valid <= 1'b0;
		hold_request = 1'b1;
		wait (hold_active);
		for (int i = 0; i < 4; i++)
			delete_timer(4'(i * 4 + 1));
		for (int i = 0; i < 4; i++)
			add_timer(8'($urandom), wall_now, 16'($urandom_range(3, 1)), 16'd0, 1'b1);
		tick_at(wall_now);
		tick_at(wall_now + 32'd3);
		wall_now = wall_now + 32'd3;
	endtask

	// Bulk random traffic; the first stretch runs with no idling at all.
	task automatic test_random_traffic();
		timer_cmd_t c;
		int         sent;
		sent    = 0;
		no_idle = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			if (sent == 60)
				no_idle = 1'b0;
			c = random_command();
			send_command(c);
			if (c.op != OP_UNUSED)
				sent++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_tick();
		test_fill_table();
		test_delete();
		test_tick_firing();
		test_backpressure();
		test_random_traffic();
		in_valid <= 1'b0;

		// drain, then leave room for a tick still scanning
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("** periodic_timer_table: PASSED **");
		else
			$display("** periodic_timer_table: FAILED **");
		$finish;
	end

endmodule
